@@ hw/rtl/bia_pkg.sv @@
// Shared constants for the burst interval analyser.
`timescale 1ns / 1ps

package bia_pkg;

    // Default widths of the sample and of the tick counters.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    // Window length after reset, in ticks.
    localparam int WINDOW_LIMIT_RESET = 50000;

    // Width and fraction bits of the reported interval.
    localparam int INTERVAL_BITS = 32;
    localparam int FRAC_BITS     = 8;

    // Configuration port geometry.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_WINDOW_LIMIT = 1'b0;

    // Flag positions in the result word's side band.
    localparam int USER_IN_BURST    = 0;
    localparam int USER_WINDOW_DONE = 1;
    localparam int USER_BITS        = 2;

endpackage

@@ hw/rtl/burst_interval_analyzer_unit.sv @@
// Top level of the burst interval analyser: window tracking, burst detection, serial divider.
`timescale 1ns / 1ps

// Usage:
// One signed voltage sample enters per word on the s_* stream; one result word leaves on
// the m_* stream for every sample. The result carries the minimum and maximum of the last
// completed window, the mean tick spacing between burst onsets (unsigned, 8 fraction bits)
// and, in tuser, the burst state after the sample and a flag marking a window close.
// The window length is set through the APB port (window_limit at byte address 0); write it
// only while no sample is in flight.
// Flow: a sample that does not start the divider goes from ST_IDLE through ST_OUT to the
// output register. A sample that closes a window with onsets recorded starts the restoring
// divider, which retires one quotient bit per cycle, COUNT_BITS + 8 bits in all; its result
// then passes through ST_OUT to the output register.
// The next sample is taken once the previous result has been moved to the output register,
// so the analyser takes no new sample while one is still being processed.
// The output register holds its word while m_tready is low; a second sample may still be
// taken and processed, and waits for the output register before its result is loaded.
// Reset clears the tick counter, the reference range and the interval, sets the onset count
// to -1 and the burst state, and restores window_limit to 50000.
module burst_interval_analyzer_unit
    import bia_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: sample
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
    // Output stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // Fields from bit 0: window_min, window_max, burst_interval_q8
    output logic [((2 * SAMPLE_BITS + INTERVAL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // Fields from bit 0: in_burst, window_done
    output logic [USER_BITS-1:0]                      m_tuser,
    // Configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]                  paddr,
    input  logic [APB_DATA_BITS-1:0]                  pwdata,
    output logic [APB_DATA_BITS-1:0]                  prdata,
    output logic                                      pready
);

    localparam int OUT_W  = ((2 * SAMPLE_BITS + INTERVAL_BITS + 7) / 8) * 8;
    localparam int QW     = COUNT_BITS + FRAC_BITS;
    localparam int STEP_W = $clog2(QW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Registers
    logic [1:0]                    state_reg, state_next;
    logic [COUNT_BITS-1:0]         limit_reg;
    logic [COUNT_BITS-1:0]         cnt_reg, cnt_next;
    logic signed [SAMPLE_BITS-1:0] run_min_reg, run_min_next;
    logic signed [SAMPLE_BITS-1:0] run_max_reg, run_max_next;
    logic signed [SAMPLE_BITS-1:0] ref_min_reg, ref_min_next;
    logic signed [SAMPLE_BITS-1:0] ref_max_reg, ref_max_next;
    logic signed [COUNT_BITS:0]    onset_reg, onset_next;
    logic                          burst_reg, burst_next;
    logic [COUNT_BITS-1:0]         sum_reg, sum_next;
    logic [COUNT_BITS-1:0]         last_reg, last_next;
    logic [INTERVAL_BITS-1:0]      ivl_reg, ivl_next;
    logic                          done_reg, done_next;

    // Divider registers: dividend shifting into the quotient, partial remainder, divisor
    logic [QW-1:0]                 dq_reg, dq_next;
    logic [COUNT_BITS:0]           rem_reg, rem_next;
    logic [COUNT_BITS:0]           dvs_reg, dvs_next;
    logic [STEP_W-1:0]             step_reg, step_next;

    // Output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]              m_tdata_reg, m_tdata_next;
    logic [USER_BITS-1:0]          m_tuser_reg, m_tuser_next;

    // Combinational helpers
    logic                          in_fire;
    logic                          cfg_wr;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          close;
    logic                          onset_pos;
    logic signed [SAMPLE_BITS-1:0] run_min_base, run_max_base;
    logic signed [COUNT_BITS:0]    onset_base;
    logic [COUNT_BITS-1:0]         sum_base, last_base, cnt_base;
    logic signed [SAMPLE_BITS:0]   diff, range;
    logic signed [SAMPLE_BITS+4:0] diff_w, range_w, d10, r9;
    logic                          rise, fall;
    logic [COUNT_BITS+1:0]         trial;
    logic [INTERVAL_BITS-1:0]      quo_sat;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign smp      = s_tdata[SAMPLE_BITS-1:0];

    // Configuration port: a single register, its low COUNT_BITS bits read back as written
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LIMIT);
    assign prdata = (paddr[2] == REG_WINDOW_LIMIT) ? APB_DATA_BITS'(limit_reg) : '0;

    // Window close test and the state as it stands after a close
    assign close        = (cnt_reg > limit_reg) || (&cnt_reg);
    assign onset_pos    = !onset_reg[COUNT_BITS] && (onset_reg != '0);
    assign ref_min_next = close ? run_min_reg : ref_min_reg;
    assign ref_max_next = close ? run_max_reg : ref_max_reg;
    assign run_min_base = close ? SMP_MAX : run_min_reg;
    assign run_max_base = close ? SMP_MIN : run_max_reg;
    assign onset_base   = close ? '0 : onset_reg;
    assign sum_base     = close ? '0 : sum_reg;
    assign last_base    = close ? '0 : last_reg;
    assign cnt_base     = close ? '0 : cnt_reg;

    // Hysteresis compares, exact: 10*(s-min) > 9*range and 10*(s-min) < range
    assign diff    = (SAMPLE_BITS+1)'(smp) - (SAMPLE_BITS+1)'(ref_min_next);
    assign range   = (SAMPLE_BITS+1)'(ref_max_next) - (SAMPLE_BITS+1)'(ref_min_next);
    assign diff_w  = (SAMPLE_BITS+5)'(diff);
    assign range_w = (SAMPLE_BITS+5)'(range);
    assign d10     = (diff_w <<< 3) + (diff_w <<< 1);
    assign r9      = (range_w <<< 3) + range_w;
    assign rise    = !burst_reg && (d10 > r9);
    assign fall    = burst_reg && (d10 < range_w);

    // One restoring divider step
    assign trial = {rem_reg, dq_reg[QW-1]} - {1'b0, dvs_reg};

    // Quotient clipped to the interval width
    generate
        if (QW > INTERVAL_BITS) begin : g_sat
            assign quo_sat = (|dq_reg[QW-1:INTERVAL_BITS]) ? '1 : dq_reg[INTERVAL_BITS-1:0];
        end
        else begin : g_nosat
            assign quo_sat = INTERVAL_BITS'(dq_reg);
        end
    endgenerate

    // Sequencer and datapath next values
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        run_min_next  = run_min_reg;
        run_max_next  = run_max_reg;
        onset_next    = onset_reg;
        burst_next    = burst_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        ivl_next      = ivl_reg;
        done_next     = done_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    done_next    = close;
                    run_min_next = (smp < run_min_base) ? smp : run_min_base;
                    run_max_next = (smp > run_max_base) ? smp : run_max_base;
                    onset_next   = onset_base;
                    sum_next     = sum_base;
                    last_next    = last_base;
                    if (rise)
                    begin
                        burst_next = 1'b1;
                        onset_next = onset_base + 1'b1;
                        sum_next   = sum_base + (cnt_base - last_base);
                        last_next  = cnt_base;
                    end
                    else if (fall)
                    begin
                        burst_next = 1'b0;
                    end
                    cnt_next = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
                    // A close with onsets on record starts the divide
                    if (close && onset_pos)
                    begin
                        dq_next    = {sum_reg, FRAC_BITS'(0)};
                        rem_next   = '0;
                        dvs_next   = onset_reg;
                        step_next  = STEP_W'(QW);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        if (close)
                        begin
                            ivl_next = '0;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    ivl_next   = quo_sat;
                    state_next = ST_OUT;
                end
                else
                begin
                    if (!trial[COUNT_BITS+1])
                    begin
                        rem_next = trial[COUNT_BITS:0];
                    end
                    else
                    begin
                        rem_next = {rem_reg[COUNT_BITS-1:0], dq_reg[QW-1]};
                    end
                    dq_next   = {dq_reg[QW-2:0], !trial[COUNT_BITS+1]};
                    step_next = step_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({ivl_reg, ref_max_reg, ref_min_reg});
                    m_tuser_next[USER_IN_BURST]    = burst_reg;
                    m_tuser_next[USER_WINDOW_DONE] = done_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            limit_reg    <= COUNT_BITS'(WINDOW_LIMIT_RESET);
            cnt_reg      <= '0;
            run_min_reg  <= SMP_MAX;
            run_max_reg  <= SMP_MIN;
            ref_min_reg  <= '0;
            ref_max_reg  <= '0;
            onset_reg    <= '1;
            burst_reg    <= 1'b1;
            sum_reg      <= '0;
            last_reg     <= '0;
            ivl_reg      <= '0;
            done_reg     <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_wr)
            begin
                limit_reg <= pwdata[COUNT_BITS-1:0];
            end
            cnt_reg      <= cnt_next;
            run_min_reg  <= run_min_next;
            run_max_reg  <= run_max_next;
            if (in_fire)
            begin
                ref_min_reg <= ref_min_next;
                ref_max_reg <= ref_max_next;
            end
            onset_reg    <= onset_next;
            burst_reg    <= burst_next;
            sum_reg      <= sum_next;
            last_reg     <= last_next;
            ivl_reg      <= ivl_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers of the divider and the output stage
    always_ff @(posedge clk)
    begin
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/bia_checker.sv @@
// Port-level checks for the burst interval analyser, bound to the top level.
`timescale 1ns / 1ps

module bia_checker
    import bia_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      s_tvalid,
    input logic                                      s_tready,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [((2 * SAMPLE_BITS + INTERVAL_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [USER_BITS-1:0]                      m_tuser
);

    localparam int RES_W = 2 * SAMPLE_BITS + INTERVAL_BITS;

    logic                          in_hs;
    logic                          out_hs;
    logic [1:0]                    pend_reg;
    logic                          seen_reg;
    logic [RES_W-1:0]              last_res_reg;
    logic signed [SAMPLE_BITS-1:0] win_min;
    logic signed [SAMPLE_BITS-1:0] win_max;

    assign in_hs   = s_tvalid && s_tready;
    assign out_hs  = m_tvalid && m_tready;
    assign win_min = m_tdata[SAMPLE_BITS-1:0];
    assign win_max = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Words taken in but not yet delivered, and the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_hs) - 2'(out_hs);
            if (out_hs)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_hs)
        begin
            last_res_reg <= m_tdata[RES_W-1:0];
        end
    end

    // A stalled result word holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // No result leaves without a sample behind it.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs |-> (pend_reg != 2'd0) || in_hs)
        else $error("result delivered without an accepted sample");

    // A closed window always spans at least one sample.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && m_tuser[USER_WINDOW_DONE] |-> win_min <= win_max)
        else $error("window minimum above window maximum");

    // Range and interval change only at a window close.
    a_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && seen_reg && !m_tuser[USER_WINDOW_DONE] |-> m_tdata[RES_W-1:0] == last_res_reg)
        else $error("window results changed without a window close");

endmodule

bind burst_interval_analyzer_unit bia_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/tb_burst_interval_analyzer_unit.sv @@
// Self-checking testbench for the burst interval analyser: stream stimulus, APB set-up and result checks.
`timescale 1ns / 1ps

module tb_burst_interval_analyzer_unit;
    import bia_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int CW = COUNT_BITS_DEF;
    localparam int MW = ((2 * SW + INTERVAL_BITS + 7) / 8) * 8;
    localparam logic signed [SW-1:0] SAMPLE_TOP    = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_BOTTOM = {1'b1, {(SW - 1){1'b0}}};
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    // One result word as the analyser should report it.
    typedef struct {
        logic signed [SW-1:0]      wmin;
        logic signed [SW-1:0]      wmax;
        logic [INTERVAL_BITS-1:0]  interval_q8;
        logic                      in_burst;
        logic                      done;
    } bia_report_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [((SW + 7) / 8) * 8 - 1:0] s_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [MW-1:0]                m_tdata;
    logic [USER_BITS-1:0]         m_tuser;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_BITS-1:0]     paddr;
    logic [APB_DATA_BITS-1:0]     pwdata;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    // Predicted state of the analyser.
    logic [CW-1:0]                win_limit_m;
    logic [CW-1:0]                tick_count;
    logic [CW-1:0]                last_onset;
    logic [CW-1:0]                onset_gap_sum;
    logic signed [SW-1:0]         run_min;
    logic signed [SW-1:0]         run_max;
    logic signed [SW-1:0]         ref_lo;
    logic signed [SW-1:0]         ref_hi;
    int                           onset_num;
    logic                         bursting;
    logic [INTERVAL_BITS-1:0]     mean_gap_q8;

    bia_report_t                  pending_reports[$];
    int                           mismatch_count = 0;
    int                           gap_pct = 0;
    int                           stall_pct = 0;
    int                           ready_hold = 0;
    int                           quiet_cycles = 0;

    // Levels of the synthetic burst waveform.
    int                           lvl_lo;
    int                           lvl_hi;
    logic                         high_phase = 1'b0;

    burst_interval_analyzer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Advance the predicted state by one sample and return the expected word.
    function automatic bia_report_t predict_tick(input logic signed [SW-1:0] s);
        bia_report_t r;
        longint span;
        longint lift;
        longint quot;
        r.done = 1'b0;
        // Window close happens before the new sample is looked at.
        if (tick_count > win_limit_m || tick_count == '1)
        begin
            r.done = 1'b1;
            ref_lo = run_min;
            ref_hi = run_max;
            run_min = SAMPLE_TOP;
            run_max = SAMPLE_BOTTOM;
            if (onset_num > 0)
            begin
                quot = (longint'(onset_gap_sum) << FRAC_BITS) / onset_num;
                mean_gap_q8 = (quot > 64'hFFFF_FFFF) ? '1 : quot[INTERVAL_BITS-1:0];
            end
            else
            begin
                mean_gap_q8 = '0;
            end
            tick_count = '0;
            onset_num = 0;
            onset_gap_sum = '0;
            last_onset = '0;
        end
        if (s < run_min)
        begin
            run_min = s;
        end
        if (s > run_max)
        begin
            run_max = s;
        end
        // Hysteresis at 90 and 10 percent of the reference range, scaled by ten.
        span = longint'(ref_hi) - longint'(ref_lo);
        lift = (longint'(s) - longint'(ref_lo)) * 10;
        if (!bursting && lift > span * 9)
        begin
            bursting = 1'b1;
            onset_num = onset_num + 1;
            onset_gap_sum = onset_gap_sum + (tick_count - last_onset);
            last_onset = tick_count;
        end
        else if (bursting && lift < span)
        begin
            bursting = 1'b0;
        end
        if (tick_count != '1)
        begin
            tick_count = tick_count + 1'b1;
        end
        r.wmin = ref_lo;
        r.wmax = ref_hi;
        r.interval_q8 = mean_gap_q8;
        r.in_burst = bursting;
        return r;
    endfunction

    // Offer one sample word, wait for it to be taken and record its expected result.
    task automatic send_sample(input logic signed [SW-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = value;
        do @(posedge clk); while (!s_tready);
        pending_reports.push_back(predict_tick(value));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Block until every expected word has come out, then return on a falling edge.
    task automatic wait_for_results();
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // APB write of the window length, only once the analyser has gone quiet.
    task automatic set_window_limit(input logic [CW-1:0] value);
        wait_for_results();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_WINDOW_LIMIT, 2'b00};
        pwdata = APB_DATA_BITS'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        win_limit_m = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Choose quiet and burst levels with a range wide enough for both thresholds.
    task automatic pick_levels();
        lvl_lo = int'($urandom_range(32000)) - 32768;
        lvl_hi = lvl_lo + int'($urandom_range(32767 - lvl_lo, 40));
    endtask

    // Mostly a square-ish burst waveform near the chosen levels, with some noise.
    function automatic logic signed [SW-1:0] next_sample();
        int span;
        int pick;
        int v;
        span = lvl_hi - lvl_lo;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            v = $urandom();
        end
        else
        begin
            if (pick < 35)
            begin
                high_phase = !high_phase;
            end
            if (pick >= 90)
            begin
                v = lvl_lo + span / 2;
            end
            else if (high_phase)
            begin
                v = lvl_hi - int'($urandom_range(span / 20));
            end
            else
            begin
                v = lvl_lo + int'($urandom_range(span / 20));
            end
        end
        return v[SW-1:0];
    endfunction

    function automatic logic [CW-1:0] pick_window_limit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            return CW'(1);
        end
        if (pick < 85)
        begin
            return CW'($urandom_range(40, 2));
        end
        return CW'($urandom_range(300, 100));
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_tready = 1'b0;
            ready_hold = ready_hold - 1;
        end
        else
        begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        mismatch_count = mismatch_count + 1;
    endtask

    // Compare each result word taken from the analyser with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        bia_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h / %b",
                         $time, m_tdata, m_tuser);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (m_tdata[SW-1:0] !== want.wmin)
                begin
                    note_mismatch("window_min", 32'(want.wmin), 32'(m_tdata[SW-1:0]));
                end
                if (m_tdata[2*SW-1:SW] !== want.wmax)
                begin
                    note_mismatch("window_max", 32'(want.wmax), 32'(m_tdata[2*SW-1:SW]));
                end
                if (m_tdata[2*SW+INTERVAL_BITS-1:2*SW] !== want.interval_q8)
                begin
                    note_mismatch("burst_interval_q8", want.interval_q8,
                                  m_tdata[2*SW+INTERVAL_BITS-1:2*SW]);
                end
                if (m_tuser[USER_IN_BURST] !== want.in_burst)
                begin
                    note_mismatch("in_burst", 32'(want.in_burst), 32'(m_tuser[USER_IN_BURST]));
                end
                if (m_tuser[USER_WINDOW_DONE] !== want.done)
                begin
                    note_mismatch("window_done", 32'(want.done),
                                  32'(m_tuser[USER_WINDOW_DONE]));
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no word moving.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (!s_tvalid && pending_reports.size() == 0))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Full-scale samples and alternating bit patterns in the first window after reset.
    task automatic test_sample_extremes();
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        send_sample('0);
        send_sample('1);
        send_sample(1);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
    endtask

    // A window limit of 1 with a flat signal (no onsets), then short windows with onsets.
    task automatic test_short_windows();
        int i;
        set_window_limit(1);
        for (i = 0; i < 6; i++)
        begin
            send_sample(100);
        end
        set_window_limit(3);
        for (i = 0; i < 12; i++)
        begin
            send_sample((i % 4 < 2) ? -1000 : 1000);
        end
    endtask

    // Burst waveforms over a range of window lengths under one idling pattern.
    task automatic test_random_traffic(input int sender_gap, input int receiver_stall,
                                       input int count);
        int i;
        gap_pct = sender_gap;
        stall_pct = receiver_stall;
        for (i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                set_window_limit(pick_window_limit());
                pick_levels();
            end
            send_sample(next_sample());
        end
    endtask

    // Largest window length: the window stays open throughout.
    task automatic test_longest_window();
        int i;
        gap_pct = 0;
        stall_pct = 0;
        set_window_limit('1);
        pick_levels();
        for (i = 0; i < 30; i++)
        begin
            send_sample(next_sample());
        end
    endtask

    // Receiver holds off for a long stretch while samples keep being offered.
    task automatic test_output_backpressure();
        int i;
        gap_pct = 0;
        stall_pct = 0;
        set_window_limit(8);
        pick_levels();
        ready_hold = HOLD_OFF_CYCLES;
        for (i = 0; i < 50; i++)
        begin
            send_sample(next_sample());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // Predicted state after reset.
        win_limit_m = CW'(WINDOW_LIMIT_RESET);
        tick_count = '0;
        last_onset = '0;
        onset_gap_sum = '0;
        run_min = SAMPLE_TOP;
        run_max = SAMPLE_BOTTOM;
        ref_lo = '0;
        ref_hi = '0;
        onset_num = -1;
        bursting = 1'b1;
        mean_gap_q8 = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_sample_extremes();
        test_short_windows();
        test_random_traffic(0, 0, 250);
        test_random_traffic(65, 0, 250);
        test_random_traffic(0, 65, 250);
        test_random_traffic(12, 12, 200);
        test_longest_window();
        test_output_backpressure();

        // Let the last words drain and allow for a divider pass still running.
        wait_for_results();
        repeat (CW + 16) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/bia_pkg.sv
hw/rtl/burst_interval_analyzer_unit.sv
hw/rtl/bia_checker.sv
dv/tb_burst_interval_analyzer_unit.sv
